### design/quadrature_position_pd_pwm_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the quadrature position controller.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef QUADRATURE_POSITION_PD_PWM_TOP_MACROS_SVH
`define QUADRATURE_POSITION_PD_PWM_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QPP_CHECK(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QPP_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/qpp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qpp_pkg
// Shared types and constants of the quadrature position PD/PWM controller.
// ---------------------------------------------------------------------------
package qpp_pkg;

    // Fraction bits of the gains.
    localparam int GAIN_FRAC_BITS = 16;

    localparam int POS_W  = 32;
    localparam int GAIN_W = 16;
    localparam int DUTY_W = 7;
    localparam int PER_W  = 16;
    localparam int PW_W   = 16;
    localparam int KIND_W = 2;
    localparam int IDX_W  = 2;
    localparam int CFG_W  = 16;

    // Clamped duty magnitude keeps its fraction bits.
    localparam int MAG_W  = DUTY_W + GAIN_FRAC_BITS;
    // Control effort: 16 bit gains times 33 bit signed operands, summed.
    localparam int ACC_W  = 52;
    // Shared multiplier operand and product widths.
    localparam int MA_W   = 34;
    localparam int MB_W   = 25;
    localparam int MP_W   = MA_W + MB_W;
    // Duty times period with the fraction bits dropped is below 100 * 2^16.
    localparam int V_W    = DUTY_W + PER_W;
    // Division by 100 as multiply by ceil(2^30 / 100) and shift; exact below 2^23.
    localparam int QUO_SHIFT = 30;
    localparam int RECIP_W   = 24;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

    localparam logic [DUTY_W-1:0] FULL_PERCENT = 7'd100;
    localparam logic [POS_W-1:0]  POS_MAX      = 32'h7fff_ffff;
    localparam logic [POS_W-1:0]  POS_MIN      = 32'h8000_0000;

    // Reset values.
    localparam logic [GAIN_W-1:0] RESET_GAIN   = 16'd328;
    localparam logic [DUTY_W-1:0] RESET_DUTY   = 7'd90;
    localparam logic [PER_W-1:0]  RESET_PERIOD = 16'd50;
    localparam logic [POS_W-1:0]  RESET_TARGET = 32'd10000;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_EDGE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REF  = 2'd2;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_GAIN_PROP  = 2'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_DIFF  = 2'd1;
    localparam logic [IDX_W-1:0] REG_DUTY_LIMIT = 2'd2;
    localparam logic [IDX_W-1:0] REG_PERIOD     = 2'd3;

    // Sequencer states of a control tick.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIFF,
        ST_MULD,
        ST_SUM,
        ST_ABS,
        ST_CLAMP,
        ST_MULW,
        ST_MULQ,
        ST_PW,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_prop;
        logic [GAIN_W-1:0] gain_diff;
        logic [DUTY_W-1:0] duty_limit;
        logic [PER_W-1:0]  period;
    } t_cfg;

    typedef struct packed {
        logic                   en;
        logic signed [MA_W-1:0] a;
        logic signed [MB_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              valid;
        logic              reverse;
        logic [PW_W-1:0]   high_time;
        logic [POS_W-1:0]  count;
        logic [POS_W-1:0]  error;
    } t_result;

endpackage

### design/quadrature_position_pd_pwm_top.sv
// Encoder edges and reference loads are applied in the idle state, which stays ready.
// A control tick runs from acceptance to its result word through the states ERR,
// DIFF, MULD, SUM, ABS, CLAMP, MULW, MULQ, PW and DONE, which run four products
// through the one shared multiplier; other items wait until the sequencer is idle.
// The result word sits in an output register; a tick waits only if it is still full.
// Reset (synchronous, active low) clears count and stored error, target 10000.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quadrature_position_pd_pwm_top
// Quadrature position counter with PD control, direction and PWM width output.
// ---------------------------------------------------------------------------
module quadrature_position_pd_pwm_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [qpp_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [qpp_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // level_a [0], level_b [1], target_pos [33:2], zero fill [39:34]
    input  logic [39:0]                   s_axis_tdata,
    // kind [1:0]
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // reverse [0], high_time [16:1], position_count [48:17],
    // pos_error [80:49], zero fill [87:81]
    output logic [87:0]                   m_axis_tdata
);
    import qpp_pkg::*;

    t_cfg    r_cfg;
    t_result w_res;
    logic    w_core_ready;
    logic    w_res_free;
    logic    r_m_valid;
    logic [80:0] r_m_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_prop  <= RESET_GAIN;
            r_cfg.gain_diff  <= RESET_GAIN;
            r_cfg.duty_limit <= RESET_DUTY;
            r_cfg.period     <= RESET_PERIOD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GAIN_PROP:  r_cfg.gain_prop  <= i_cfg_data;
                REG_GAIN_DIFF:  r_cfg.gain_diff  <= i_cfg_data;
                REG_DUTY_LIMIT: r_cfg.duty_limit <= i_cfg_data[DUTY_W-1:0];
                REG_PERIOD:     r_cfg.period     <= i_cfg_data;
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    assign s_axis_tready = w_core_ready;
    assign w_res_free    = !r_m_valid || m_axis_tready;

    qpp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (s_axis_tvalid && w_core_ready),
        .i_kind       (s_axis_tuser),
        .i_level_a    (s_axis_tdata[0]),
        .i_level_b    (s_axis_tdata[1]),
        .i_target_pos (s_axis_tdata[33:2]),
        .o_ready      (w_core_ready),
        .i_res_free   (w_res_free),
        .o_res        (w_res)
    );

    // Output register holds the result word until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res.valid) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_m_data <= {w_res.error, w_res.count, w_res.high_time, w_res.reverse};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'd0, r_m_data};

endmodule

### design/qpp_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qpp_mul
// Shared signed multiplier with a registered product, one issue per cycle.
// ---------------------------------------------------------------------------
module qpp_mul (
    input  logic                              i_clk,
    input  qpp_pkg::t_mul_req                 i_req,
    output logic signed [qpp_pkg::MP_W-1:0]   o_prod
);
    import qpp_pkg::*;

    logic signed [MP_W-1:0] r_prod;
    logic signed [MP_W-1:0] n_prod;

    // The product register only loads when an operation is issued.
    always_comb begin
        n_prod = i_req.a * i_req.b;
    end

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

### design/qpp_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// qpp_core
// Encoder count, target and PD sequencer that reuses one multiplier.
// ---------------------------------------------------------------------------
`include "quadrature_position_pd_pwm_top_macros.svh"

module qpp_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qpp_pkg::t_cfg                 i_cfg,
    input  logic                          i_in_valid,
    input  logic [qpp_pkg::KIND_W-1:0]    i_kind,
    input  logic                          i_level_a,
    input  logic                          i_level_b,
    input  logic [qpp_pkg::POS_W-1:0]     i_target_pos,
    output logic                          o_ready,
    input  logic                          i_res_free,
    output qpp_pkg::t_result              o_res
);
    import qpp_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [POS_W-1:0]  r_count;
    logic [POS_W-1:0]  r_target;
    logic [POS_W-1:0]  r_last;
    logic [POS_W-1:0]  r_err;
    logic [POS_W:0]    r_diff;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  r_abs;
    logic              r_rev;
    logic [MAG_W-1:0]  r_mag;
    logic [PW_W-1:0]   r_pw;

    logic signed [MP_W-1:0] w_prod;
    t_mul_req               w_req;

    logic [POS_W:0]    w_dist;
    logic [POS_W-1:0]  w_err_sat;
    logic [DUTY_W-1:0] w_duty_cap;
    logic [MAG_W-1:0]  w_limit;
    logic [ACC_W-1:0]  w_limit_ext;

    // Saturated error and duty limit.
    always_comb begin
        w_dist = {r_target[POS_W-1], r_target} - {r_count[POS_W-1], r_count};
        if (w_dist[POS_W] != w_dist[POS_W-1]) begin
            w_err_sat = w_dist[POS_W] ? POS_MIN : POS_MAX;
        end else begin
            w_err_sat = w_dist[POS_W-1:0];
        end
        w_duty_cap  = (i_cfg.duty_limit > FULL_PERCENT) ? FULL_PERCENT : i_cfg.duty_limit;
        w_limit     = {w_duty_cap, {GAIN_FRAC_BITS{1'b0}}};
        w_limit_ext = {{(ACC_W - MAG_W){1'b0}}, w_limit};
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && (i_kind == KIND_TICK)) begin
                    n_state = ST_ERR;
                end
            end
            ST_ERR:   n_state = ST_DIFF;
            ST_DIFF:  n_state = ST_MULD;
            ST_MULD:  n_state = ST_SUM;
            ST_SUM:   n_state = ST_ABS;
            ST_ABS:   n_state = ST_CLAMP;
            ST_CLAMP: n_state = ST_MULW;
            ST_MULW:  n_state = ST_MULQ;
            ST_MULQ:  n_state = ST_PW;
            ST_PW:    n_state = ST_DONE;
            ST_DONE: begin
                if (i_res_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operands, ready and result word.
    always_comb begin
        w_req.en = 1'b0;
        w_req.a  = '0;
        w_req.b  = '0;
        o_ready  = 1'b0;
        o_res.valid     = 1'b0;
        o_res.reverse   = r_rev;
        o_res.high_time = r_pw;
        o_res.count     = r_count;
        o_res.error     = r_err;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
            end
            ST_DIFF: begin
                w_req.en = 1'b1;
                w_req.a  = {{(MA_W - POS_W){r_err[POS_W-1]}}, r_err};
                w_req.b  = {{(MB_W - GAIN_W){1'b0}}, i_cfg.gain_prop};
            end
            ST_MULD: begin
                w_req.en = 1'b1;
                w_req.a  = {{(MA_W - POS_W - 1){r_diff[POS_W]}}, r_diff};
                w_req.b  = {{(MB_W - GAIN_W){1'b0}}, i_cfg.gain_diff};
            end
            ST_MULW: begin
                w_req.en = 1'b1;
                w_req.a  = {{(MA_W - MAG_W){1'b0}}, r_mag};
                w_req.b  = {{(MB_W - PER_W){1'b0}}, i_cfg.period};
            end
            ST_MULQ: begin
                w_req.en = 1'b1;
                w_req.a  = {{(MA_W - V_W){1'b0}}, w_prod[GAIN_FRAC_BITS+V_W-1:GAIN_FRAC_BITS]};
                w_req.b  = {{(MB_W - RECIP_W){1'b0}}, RECIP_100};
            end
            ST_DONE: begin
                o_res.valid = i_res_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    qpp_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_prod (w_prod)
    );

    // Control state: sequencer, count, target and stored error.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_target <= RESET_TARGET;
            r_last   <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_IDLE) && i_in_valid) begin
                if (i_kind == KIND_EDGE) begin
                    r_count <= (i_level_a ^ i_level_b) ? r_count + 32'd1 : r_count - 32'd1;
                end else if (i_kind == KIND_REF) begin
                    r_target <= i_target_pos;
                end
            end
            if (o_res.valid) begin
                r_last <= r_err;
            end
        end
    end

    // Datapath registers of the tick sequence.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_ERR:   r_err  <= w_err_sat;
            ST_DIFF:  r_diff <= {r_err[POS_W-1], r_err} - {r_last[POS_W-1], r_last};
            ST_MULD:  r_acc  <= w_prod[ACC_W-1:0];
            ST_SUM:   r_acc  <= r_acc + w_prod[ACC_W-1:0];
            ST_ABS: begin
                r_rev <= r_acc[ACC_W-1];
                r_abs <= r_acc[ACC_W-1] ? (~r_acc + 1'b1) : r_acc;
            end
            ST_CLAMP: r_mag  <= (r_abs > w_limit_ext) ? w_limit : r_abs[MAG_W-1:0];
            ST_PW:    r_pw   <= w_prod[QUO_SHIFT+PW_W-1:QUO_SHIFT];
            default: begin
                r_pw <= r_pw;
            end
        endcase
    end

    `QPP_CHECK_NEXT(a_tick_starts, (r_state == ST_IDLE) && i_in_valid && (i_kind == KIND_TICK), (r_state == ST_ERR), "tick did not start the sequence")
    `QPP_CHECK_NEXT(a_edge_step, (r_state == ST_IDLE) && i_in_valid && (i_kind == KIND_EDGE), ((r_count - $past(r_count)) == ($past(i_level_a ^ i_level_b) ? 32'd1 : 32'hffff_ffff)), "encoder count did not move by one")
    `QPP_CHECK_NEXT(a_mag_limited, (r_state == ST_CLAMP), (r_mag <= w_limit), "duty magnitude above limit")
    `QPP_CHECK(a_res_slot, o_res.valid, i_res_free && (r_state == ST_DONE), "result word issued into a full output slot")

endmodule
